// File: rtl/core/vps_pkg.sv
// shared types, constants and helpers for the verlet particle step block
package vps_pkg;

  // table size limits
  localparam int MAX_PARTICLES_DEF = 64;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;

  // field widths
  localparam int POS_W  = 32;
  localparam int RAD_W  = 6;
  localparam int DT_W   = 16;
  localparam int GRAV_W = 16;
  localparam int WIN_W  = 12;
  localparam int FRAC_W = 16;

  // iterative unit lengths
  localparam int ROOT_STEPS = 24;
  localparam int DIV_STEPS  = 24;
  localparam int ITER_W     = 5;

  // configuration register reset values
  localparam logic [WIN_W-1:0]  WIDTH_RST   = 12'd1600;
  localparam logic [WIN_W-1:0]  HEIGHT_RST  = 12'd900;
  localparam logic [GRAV_W-1:0] GRAVITY_RST = 16'd981;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_GRAVITY = 2'd2;

  // input commands
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ADD_OK = 2'd0,
    KIND_FULL   = 2'd1,
    KIND_POS    = 2'd2
  } kind_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE      = 5'd0,
    OP_LOAD_IN   = 5'd1,
    OP_ADD       = 5'd2,
    OP_GMUL_DT   = 5'd3,
    OP_GMUL_G    = 5'd4,
    OP_READ      = 5'd5,
    OP_VCALC     = 5'd6,
    OP_VWRITE    = 5'd7,
    OP_PCHECK    = 5'd8,
    OP_PSQX      = 5'd9,
    OP_PSQY      = 5'd10,
    OP_PSUM      = 5'd11,
    OP_SQRT_INIT = 5'd12,
    OP_SQRT_STEP = 5'd13,
    OP_DELTA     = 5'd14,
    OP_MULX      = 5'd15,
    OP_MULY      = 5'd16,
    OP_DIV_INIT  = 5'd17,
    OP_DIV_STEP  = 5'd18,
    OP_WRITE_I   = 5'd19,
    OP_WRITE_J   = 5'd20,
    OP_EMIT      = 5'd21
  } dp_op_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
    logic             last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             far;
    logic             pair_ok;
    logic             out_free;
  } dp_status_t;

  // saturate a wide signed value to the position range
  function automatic logic signed [POS_W-1:0] sat32(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sh07FFFFFFF;
    lo = -36'sh080000000;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[POS_W-1:0];
    end
  endfunction

endpackage

// File: rtl/core/vps_ctrl.sv
// sequencer for add, integrate, pair resolve and report phases
module vps_ctrl
  import vps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       in_cmd,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [22:0] {
    S_IDLE       = 23'd1 << 0,
    S_ADD        = 23'd1 << 1,
    S_GMUL_DT    = 23'd1 << 2,
    S_GMUL_G     = 23'd1 << 3,
    S_V_READ     = 23'd1 << 4,
    S_V_CALC     = 23'd1 << 5,
    S_V_WRITE    = 23'd1 << 6,
    S_P_READ     = 23'd1 << 7,
    S_P_CHECK    = 23'd1 << 8,
    S_P_SQX      = 23'd1 << 9,
    S_P_SQY      = 23'd1 << 10,
    S_P_SUM      = 23'd1 << 11,
    S_P_TEST     = 23'd1 << 12,
    S_P_SQRT     = 23'd1 << 13,
    S_P_DELTA    = 23'd1 << 14,
    S_P_MULX     = 23'd1 << 15,
    S_P_MULY     = 23'd1 << 16,
    S_P_DIV_INIT = 23'd1 << 17,
    S_P_DIV      = 23'd1 << 18,
    S_P_WRITE_I  = 23'd1 << 19,
    S_P_WRITE_J  = 23'd1 << 20,
    S_O_READ     = 23'd1 << 21,
    S_O_EMIT     = 23'd1 << 22
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [ITER_W-1:0] it_r, it_nxt;

  logic [CNT_W-1:0]  count;
  logic              k_more;
  logic              j_more;
  logic              i_more;

  assign count  = status.count;
  assign k_more = (k_r + CNT_W'(1)) < count;
  assign j_more = (j_r + CNT_W'(1)) < count;
  assign i_more = (i_r + CNT_W'(2)) < count;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      it_r    <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      it_r    <= it_nxt;
    end
  end

  // next state and datapath command
  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    it_nxt     = it_r;
    in_tready  = 1'b0;
    cmd.op     = OP_NONE;
    cmd.addr_a = k_r[IDX_W-1:0];
    cmd.addr_b = j_r[IDX_W-1:0];
    cmd.last   = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = OP_LOAD_IN;
          if (in_cmd == CMD_ADD) begin
            state_nxt = S_ADD;
          end else if (count != '0) begin
            state_nxt = S_GMUL_DT;
          end
        end
      end
      S_ADD: begin
        cmd.op = OP_ADD;
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_GMUL_DT: begin
        cmd.op    = OP_GMUL_DT;
        state_nxt = S_GMUL_G;
      end
      S_GMUL_G: begin
        cmd.op    = OP_GMUL_G;
        k_nxt     = '0;
        state_nxt = S_V_READ;
      end
      S_V_READ: begin
        cmd.op    = OP_READ;
        state_nxt = S_V_CALC;
      end
      S_V_CALC: begin
        cmd.op    = OP_VCALC;
        state_nxt = S_V_WRITE;
      end
      S_V_WRITE: begin
        cmd.op = OP_VWRITE;
        if (k_more) begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_V_READ;
        end else if (count >= CNT_W'(2)) begin
          i_nxt     = '0;
          j_nxt     = CNT_W'(1);
          state_nxt = S_P_READ;
        end else begin
          k_nxt     = '0;
          state_nxt = S_O_READ;
        end
      end
      S_P_READ: begin
        cmd.op     = OP_READ;
        cmd.addr_a = i_r[IDX_W-1:0];
        state_nxt  = S_P_CHECK;
      end
      S_P_CHECK: begin
        cmd.op = OP_PCHECK;
        if (!status.far) begin
          state_nxt = S_P_SQX;
        end
      end
      S_P_SQX: begin
        cmd.op    = OP_PSQX;
        state_nxt = S_P_SQY;
      end
      S_P_SQY: begin
        cmd.op    = OP_PSQY;
        state_nxt = S_P_SUM;
      end
      S_P_SUM: begin
        cmd.op    = OP_PSUM;
        state_nxt = S_P_TEST;
      end
      S_P_TEST: begin
        cmd.op = OP_SQRT_INIT;
        it_nxt = '0;
        if (status.pair_ok) begin
          state_nxt = S_P_SQRT;
        end
      end
      S_P_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        it_nxt = it_r + ITER_W'(1);
        if (it_r == ITER_W'(ROOT_STEPS - 1)) begin
          state_nxt = S_P_DELTA;
        end
      end
      S_P_DELTA: begin
        cmd.op    = OP_DELTA;
        state_nxt = S_P_MULX;
      end
      S_P_MULX: begin
        cmd.op    = OP_MULX;
        state_nxt = S_P_MULY;
      end
      S_P_MULY: begin
        cmd.op    = OP_MULY;
        state_nxt = S_P_DIV_INIT;
      end
      S_P_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        it_nxt    = '0;
        state_nxt = S_P_DIV;
      end
      S_P_DIV: begin
        cmd.op = OP_DIV_STEP;
        it_nxt = it_r + ITER_W'(1);
        if (it_r == ITER_W'(DIV_STEPS - 1)) begin
          state_nxt = S_P_WRITE_I;
        end
      end
      S_P_WRITE_I: begin
        cmd.op     = OP_WRITE_I;
        cmd.addr_a = i_r[IDX_W-1:0];
        state_nxt  = S_P_WRITE_J;
      end
      S_P_WRITE_J: begin
        cmd.op    = OP_WRITE_J;
        state_nxt = S_P_READ;
      end
      S_O_READ: begin
        cmd.op    = OP_READ;
        state_nxt = S_O_EMIT;
      end
      S_O_EMIT: begin
        cmd.op   = OP_EMIT;
        cmd.last = !k_more;
        if (status.out_free) begin
          if (k_more) begin
            k_nxt     = k_r + CNT_W'(1);
            state_nxt = S_O_READ;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // move to the next pair after a skip or a write-back
    if ((state_r == S_P_CHECK && status.far) ||
        (state_r == S_P_TEST && !status.pair_ok) ||
        state_r == S_P_WRITE_J) begin
      if (j_more) begin
        j_nxt     = j_r + CNT_W'(1);
        state_nxt = S_P_READ;
      end else if (i_more) begin
        i_nxt     = i_r + CNT_W'(1);
        j_nxt     = i_r + CNT_W'(2);
        state_nxt = S_P_READ;
      end else begin
        k_nxt     = '0;
        state_nxt = S_O_READ;
      end
    end
  end

  // pair indexes stay ordered and inside the table
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P_READ) |-> (i_r < j_r && j_r < count))
    else $error("pair indexes out of order");

  // iteration counter stays inside the root loop
  a_root_iter: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P_SQRT) |-> (it_r < ITER_W'(ROOT_STEPS)))
    else $error("root iteration overrun");

  // a step on an empty table yields nothing and returns to idle
  a_empty_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_tvalid && in_cmd == CMD_STEP && count == '0)
      |=> (state_r == S_IDLE))
    else $error("empty step left idle");

  // report phase only reads slots that exist
  a_report_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_O_READ) |-> (k_r < count))
    else $error("report index past table");

endmodule

// File: rtl/core/vps_dpath.sv
// particle table memories, arithmetic units and result register
module vps_dpath
  import vps_pkg::*;
#(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  input  logic [WIN_W-1:0]         win_w,
  input  logic [WIN_W-1:0]         win_h,
  input  logic [GRAV_W-1:0]        grav,
  input  logic signed [POS_W-1:0]  in_x,
  input  logic signed [POS_W-1:0]  in_y,
  input  logic [RAD_W-1:0]         in_rad,
  input  logic [DT_W-1:0]          in_dt,
  output logic                     out_valid,
  input  logic                     out_ready,
  output kind_t                    out_kind,
  output logic [IDX_W-1:0]         out_index,
  output logic signed [POS_W-1:0]  out_x,
  output logic signed [POS_W-1:0]  out_y,
  output logic                     out_last
);

  localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  // particle table
  logic signed [POS_W-1:0] cx_mem [MAX_PARTICLES];
  logic signed [POS_W-1:0] cy_mem [MAX_PARTICLES];
  logic signed [POS_W-1:0] px_mem [MAX_PARTICLES];
  logic signed [POS_W-1:0] py_mem [MAX_PARTICLES];
  logic [RAD_W-1:0]        r_mem  [MAX_PARTICLES];

  // read data
  logic signed [POS_W-1:0] a_cx_r, a_cy_r, a_px_r, a_py_r, b_cx_r, b_cy_r;
  logic [RAD_W-1:0]        a_rad_r, b_rad_r;

  // latched input transaction
  logic signed [POS_W-1:0] in_x_r, in_y_r;
  logic [RAD_W-1:0]        in_rad_r;
  logic [DT_W-1:0]         in_dt_r;

  logic [CNT_W-1:0]        count_r, count_nxt;

  // step and pair registers
  logic [31:0]             dt2_r;
  logic [32:0]             gterm_r;
  logic signed [POS_W-1:0] nx_r, ny_r;
  logic [23:0]             adx_r, ady_r;
  logic                    sgnx_r, sgny_r;
  logic [22:0]             rs_r;
  logic [45:0]             rs2_r;
  logic [47:0]             sqx_r, sqy_r;
  logic [48:0]             d2_r;
  logic [47:0]             n_r, root_r, bit_r;
  logic [23:0]             delta_r;
  logic [47:0]             mx_r, my_r;
  logic [24:0]             remx_r, remy_r;
  logic [23:0]             qx_r, qy_r;

  // result register
  logic                    out_valid_r, out_valid_nxt;
  kind_t                   out_kind_r;
  logic [IDX_W-1:0]        out_index_r;
  logic signed [POS_W-1:0] out_x_r, out_y_r;
  logic                    out_last_r;

  logic                    out_free;
  logic                    table_full;
  logic [IW-1:0]           ra, rb, wa;

  assign out_free   = !out_valid_r || out_ready;
  assign table_full = !(count_r < CNT_W'(MAX_PARTICLES));
  assign ra         = cmd.addr_a[IW-1:0];
  assign rb         = cmd.addr_b[IW-1:0];

  // pair proximity test on the read data
  logic signed [35:0] dxs, dys, rs36;
  logic [22:0]        rs_sum;
  logic               far;
  always_comb begin
    rs_sum = {10'd0, ({1'b0, a_rad_r} + {1'b0, b_rad_r})} << FRAC_W;
    rs36   = $signed({13'd0, rs_sum});
    dxs    = 36'(a_cx_r) - 36'(b_cx_r);
    dys    = 36'(a_cy_r) - 36'(b_cy_r);
    far    = (dxs >= rs36) || (-dxs >= rs36) || (dys >= rs36) || (-dys >= rs36);
  end

  assign status.count    = count_r;
  assign status.far      = far;
  assign status.pair_ok  = (d2_r != '0) && (d2_r < {3'd0, rs2_r});
  assign status.out_free = out_free;

  // verlet update of one particle
  logic signed [35:0] tx, ty;
  always_comb begin
    tx = 36'(a_cx_r) + 36'(a_cx_r) - 36'(a_px_r);
    ty = 36'(a_cy_r) + 36'(a_cy_r) - 36'(a_py_r) + $signed({3'd0, gterm_r});
  end

  // window clamp
  logic signed [35:0] rad36, limx, limy, clx, cly;
  always_comb begin
    rad36 = $signed({14'd0, a_rad_r, 16'd0});
    limx  = $signed({8'd0, win_w, 16'd0});
    limy  = $signed({8'd0, win_h, 16'd0});
    if (36'(nx_r) - rad36 < 36'sd0) begin
      clx = rad36;
    end else if (36'(nx_r) + rad36 > limx) begin
      clx = limx - rad36;
    end else begin
      clx = 36'(nx_r);
    end
    if (36'(ny_r) - rad36 < 36'sd0) begin
      cly = rad36;
    end else if (36'(ny_r) + rad36 > limy) begin
      cly = limy - rad36;
    end else begin
      cly = 36'(ny_r);
    end
  end

  // root step
  logic [47:0] trial;
  assign trial = root_r + bit_r;

  // divider steps for both axes against the shared divisor
  logic [23:0] root_q;
  logic [24:0] dvsr;
  logic [25:0] tdx, tdy;
  logic        gex, gey;
  logic [48:0] numx, numy;
  always_comb begin
    root_q = root_r[23:0];
    dvsr   = {root_q, 1'b0};
    tdx    = {remx_r, qx_r[23]};
    tdy    = {remy_r, qy_r[23]};
    gex    = tdx >= {1'b0, dvsr};
    gey    = tdy >= {1'b0, dvsr};
    numx   = {1'b0, mx_r} + {25'd0, root_q};
    numy   = {1'b0, my_r} + {25'd0, root_q};
  end

  // signed push per axis
  logic signed [35:0] pushx, pushy;
  always_comb begin
    pushx = sgnx_r ? -$signed({12'd0, qx_r}) : $signed({12'd0, qx_r});
    pushy = sgny_r ? -$signed({12'd0, qy_r}) : $signed({12'd0, qy_r});
  end

  // table write port
  logic                    wr_cur, wr_prev, wr_rad;
  logic signed [POS_W-1:0] wr_cx, wr_cy, wr_px, wr_py;
  always_comb begin
    wr_cur  = 1'b0;
    wr_prev = 1'b0;
    wr_rad  = 1'b0;
    wa      = ra;
    wr_cx   = in_x_r;
    wr_cy   = in_y_r;
    wr_px   = in_x_r;
    wr_py   = in_y_r;
    case (cmd.op)
      OP_ADD: begin
        if (out_free && !table_full) begin
          wr_cur  = 1'b1;
          wr_prev = 1'b1;
          wr_rad  = 1'b1;
          wa      = count_r[IW-1:0];
        end
      end
      OP_VWRITE: begin
        wr_cur  = 1'b1;
        wr_prev = 1'b1;
        wr_cx   = clx[POS_W-1:0];
        wr_cy   = cly[POS_W-1:0];
        wr_px   = a_cx_r;
        wr_py   = a_cy_r;
      end
      OP_WRITE_I: begin
        wr_cur = 1'b1;
        wr_cx  = sat32(36'(a_cx_r) + pushx);
        wr_cy  = sat32(36'(a_cy_r) + pushy);
      end
      OP_WRITE_J: begin
        wr_cur = 1'b1;
        wa     = rb;
        wr_cx  = sat32(36'(b_cx_r) - pushx);
        wr_cy  = sat32(36'(b_cy_r) - pushy);
      end
      default: begin
        wr_cur = 1'b0;
      end
    endcase
  end

  // table memories
  always_ff @(posedge clk) begin
    if (wr_cur) begin
      cx_mem[wa] <= wr_cx;
      cy_mem[wa] <= wr_cy;
    end
    if (wr_prev) begin
      px_mem[wa] <= wr_px;
      py_mem[wa] <= wr_py;
    end
    if (wr_rad) begin
      r_mem[wa] <= in_rad_r;
    end
    if (cmd.op == OP_READ) begin
      a_cx_r  <= cx_mem[ra];
      a_cy_r  <= cy_mem[ra];
      a_px_r  <= px_mem[ra];
      a_py_r  <= py_mem[ra];
      a_rad_r <= r_mem[ra];
      b_cx_r  <= cx_mem[rb];
      b_cy_r  <= cy_mem[rb];
      b_rad_r <= r_mem[rb];
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD_IN: begin
        in_x_r   <= in_x;
        in_y_r   <= in_y;
        in_rad_r <= in_rad;
        in_dt_r  <= in_dt;
      end
      OP_GMUL_DT: begin
        dt2_r <= {16'd0, in_dt_r} * {16'd0, in_dt_r};
      end
      OP_GMUL_G: begin
        gterm_r <= 33'(({16'd0, grav} * {16'd0, dt2_r} + 48'd32768) >> FRAC_W);
      end
      OP_VCALC: begin
        nx_r <= sat32(tx);
        ny_r <= sat32(ty);
      end
      OP_PCHECK: begin
        adx_r  <= dxs[35] ? 24'(-dxs) : dxs[23:0];
        ady_r  <= dys[35] ? 24'(-dys) : dys[23:0];
        sgnx_r <= dxs[35];
        sgny_r <= dys[35];
        rs_r   <= rs_sum;
      end
      OP_PSQX: begin
        sqx_r <= adx_r * adx_r;
        rs2_r <= rs_r * rs_r;
      end
      OP_PSQY: begin
        sqy_r <= ady_r * ady_r;
      end
      OP_PSUM: begin
        d2_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
      end
      OP_SQRT_INIT: begin
        n_r    <= d2_r[47:0];
        root_r <= '0;
        bit_r  <= 48'd1 << 46;
      end
      OP_SQRT_STEP: begin
        if (n_r >= trial) begin
          n_r    <= n_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_DELTA: begin
        delta_r <= {1'b0, rs_r} - root_q;
      end
      OP_MULX: begin
        mx_r <= adx_r * delta_r;
      end
      OP_MULY: begin
        my_r <= ady_r * delta_r;
      end
      OP_DIV_INIT: begin
        remx_r <= numx[48:24];
        qx_r   <= numx[23:0];
        remy_r <= numy[48:24];
        qy_r   <= numy[23:0];
      end
      OP_DIV_STEP: begin
        remx_r <= gex ? 25'(tdx - {1'b0, dvsr}) : tdx[24:0];
        remy_r <= gey ? 25'(tdy - {1'b0, dvsr}) : tdy[24:0];
        qx_r   <= {qx_r[22:0], gex};
        qy_r   <= {qy_r[22:0], gey};
      end
      default: begin
        dt2_r <= dt2_r;
      end
    endcase
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (out_free && cmd.op == OP_ADD) begin
      out_last_r <= 1'b1;
      if (table_full) begin
        out_kind_r  <= KIND_FULL;
        out_index_r <= '0;
        out_x_r     <= '0;
        out_y_r     <= '0;
      end else begin
        out_kind_r  <= KIND_ADD_OK;
        out_index_r <= count_r[IDX_W-1:0];
        out_x_r     <= in_x_r;
        out_y_r     <= in_y_r;
      end
    end else if (out_free && cmd.op == OP_EMIT) begin
      out_last_r  <= cmd.last;
      out_kind_r  <= KIND_POS;
      out_index_r <= cmd.addr_a;
      out_x_r     <= a_cx_r;
      out_y_r     <= a_cy_r;
    end
  end

  // result valid and particle count
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    count_nxt     = count_r;
    if (out_free && (cmd.op == OP_ADD || cmd.op == OP_EMIT)) begin
      out_valid_nxt = 1'b1;
    end
    if (out_free && cmd.op == OP_ADD && !table_full) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_index = out_index_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_last  = out_last_r;

  // table never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PARTICLES))
    else $error("particle count past table depth");

  // a pair only reaches the root unit with overlap and distinct centers
  a_root_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_SQRT_STEP && $past(cmd.op) == OP_SQRT_INIT)
      |-> (rs2_r != '0 && n_r != '0))
    else $error("root started on a non-overlapping pair");

endmodule

// File: rtl/core/verlet_particle_step.sv
// top level of the verlet particle step block
//
// Input stream: in_tuser selects add (0) or step (1). An add appends a particle
// at rest and returns one transaction: accepted with its slot and position, or
// table full with zero fields. A step integrates every particle, clamps it to
// the window, resolves all pairs i<j in order, then returns one position
// transaction per particle in slot order; out_tlast marks the final one. A
// step on an empty table returns nothing.
// Pairs without contact are skipped after the box test or the distance test;
// a touching pair runs through the root and the divide in the shared pair
// unit. One transaction is processed at a time; in_tready is high only while
// the sequencer is idle.
// Reset clears the particle count and loads the window and gravity defaults;
// table entries need no clearing. A stalled output holds the result register
// and the sequencer waits; the next input is taken while the last result waits.
// Configuration registers (APB, 32-bit): 0x0 width, 0x4 height, 0x8 gravity.
module verlet_particle_step
  import vps_pkg::*;
#(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: spawn_x[31:0], spawn_y[63:32], spawn_radius[69:64], time_step[85:70]
  input  logic [87:0] in_tdata,
  // tuser: command[0]
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: particle_index[5:0], position_x[37:6], position_y[69:38]
  output logic [71:0] out_tdata,
  // tuser: result_kind[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [WIN_W-1:0]        width_r, height_r;
  logic [GRAV_W-1:0]       gravity_r;
  logic                    cfg_wr;
  dp_cmd_t                 cmd;
  dp_status_t              status;
  kind_t                   out_kind;
  logic [IDX_W-1:0]        out_index;
  logic signed [POS_W-1:0] out_x, out_y;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RST;
      height_r  <= HEIGHT_RST;
      gravity_r <= GRAVITY_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_WIDTH:   width_r   <= cfg_pwdata[WIN_W-1:0];
        REG_HEIGHT:  height_r  <= cfg_pwdata[WIN_W-1:0];
        REG_GRAVITY: gravity_r <= cfg_pwdata[GRAV_W-1:0];
        default:     width_r   <= width_r;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_paddr[3:2])
      REG_WIDTH:   cfg_prdata = {20'd0, width_r};
      REG_HEIGHT:  cfg_prdata = {20'd0, height_r};
      REG_GRAVITY: cfg_prdata = {16'd0, gravity_r};
      default:     cfg_prdata = '0;
    endcase
  end

  vps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .cmd       (cmd),
    .status    (status)
  );

  vps_dpath #(
    .MAX_PARTICLES(MAX_PARTICLES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .win_w     (width_r),
    .win_h     (height_r),
    .grav      (gravity_r),
    .in_x      (in_tdata[31:0]),
    .in_y      (in_tdata[63:32]),
    .in_rad    (in_tdata[69:64]),
    .in_dt     (in_tdata[85:70]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_kind),
    .out_index (out_index),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_last  (out_tlast)
  );

  // result packing
  assign out_tdata = {2'b00, out_y, out_x, out_index};
  assign out_tuser = out_kind;

endmodule

// File: tb/tb_top.sv
// testbench for the verlet particle step block: directed and random stimulus, scoreboard checker
module tb_top
  import vps_pkg::*;
();

  localparam int  TABLE_SIZE  = 64;
  localparam int  CYCLE_LIMIT = 4000000;
  localparam int  SMALL_TABLE = 12;
  localparam int  DRAIN_WAIT  = 64;

  typedef struct {
    kind_t       kind;
    logic [5:0]  idx;
    logic [31:0] px;
    logic [31:0] py;
    logic        last;
  } particle_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [87:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // shadow of the particle table and registers
  longint      cur_x [TABLE_SIZE];
  longint      cur_y [TABLE_SIZE];
  longint      old_x [TABLE_SIZE];
  longint      old_y [TABLE_SIZE];
  longint      rad   [TABLE_SIZE];
  int          shadow_count = 0;
  longint      win_w = 1600;
  longint      win_h = 900;
  longint      grav  = 981;

  particle_result_t pending_results[$];
  int          fail_count = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          full_seen = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  verlet_particle_step dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #2 clk = ~clk;

  // run-length guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL verlet_particle_step");
      $finish;
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom % 100) >= recv_stall_pct;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint wall_clamp(longint p, longint r, longint lim);
    if (p - r < 0) return r;
    if (p + r > lim) return lim - r;
    return p;
  endfunction

  function automatic longint nearest_div(longint num, longint den);
    longint unsigned m;
    longint unsigned q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // queue one expected result behind the others
  function automatic void queue_result(particle_result_t res);
    pending_results.insert(pending_results.size(), res);
  endfunction

  // push two touching circles apart along their center axis
  task automatic separate_pair(int i, int j);
    longint rs, dx, dy, root_len, delta, px, py;
    longint unsigned d2;
    rs = (rad[i] + rad[j]) <<< 16;
    dx = cur_x[i] - cur_x[j];
    dy = cur_y[i] - cur_y[j];
    if (dx >= rs || -dx >= rs || dy >= rs || -dy >= rs) return;
    d2 = dx * dx + dy * dy;
    if (d2 == 0 || d2 >= rs * rs) return;
    root_len = int_root(d2);
    delta = rs - root_len;
    px = nearest_div(dx * delta, 2 * root_len);
    py = nearest_div(dy * delta, 2 * root_len);
    cur_x[i] = clip32(cur_x[i] + px);
    cur_y[i] = clip32(cur_y[i] + py);
    cur_x[j] = clip32(cur_x[j] - px);
    cur_y[j] = clip32(cur_y[j] - py);
  endtask

  // expected results of one accepted transaction
  task automatic predict_motion(logic cmd, logic [31:0] sx, logic [31:0] sy,
                                logic [5:0] sr, logic [15:0] dt);
    particle_result_t res;
    longint unsigned g_term;
    longint unsigned dt2;
    longint cx, cy, r, nx, ny;
    if (cmd == CMD_ADD) begin
      if (shadow_count < TABLE_SIZE) begin
        cur_x[shadow_count] = longint'($signed(sx));
        cur_y[shadow_count] = longint'($signed(sy));
        old_x[shadow_count] = cur_x[shadow_count];
        old_y[shadow_count] = cur_y[shadow_count];
        rad[shadow_count] = sr;
        res = '{KIND_ADD_OK, shadow_count[5:0], sx, sy, 1'b1};
        shadow_count++;
      end else begin
        res = '{KIND_FULL, 6'd0, 32'd0, 32'd0, 1'b1};
      end
      queue_result(res);
      return;
    end
    dt2 = longint'(dt) * longint'(dt);
    g_term = (longint'(grav) * dt2 + 64'd32768) >> 16;
    for (int k = 0; k < shadow_count; k++) begin
      cx = cur_x[k];
      cy = cur_y[k];
      r = rad[k] <<< 16;
      nx = clip32(cx + (cx - old_x[k]));
      ny = clip32(cy + (cy - old_y[k]) + longint'(g_term));
      old_x[k] = cx;
      old_y[k] = cy;
      cur_x[k] = clip32(wall_clamp(nx, r, win_w <<< 16));
      cur_y[k] = clip32(wall_clamp(ny, r, win_h <<< 16));
    end
    for (int i = 0; i < shadow_count; i++)
      for (int j = i + 1; j < shadow_count; j++)
        separate_pair(i, j);
    for (int k = 0; k < shadow_count; k++) begin
      res = '{KIND_POS, k[5:0], cur_x[k][31:0], cur_y[k][31:0], k + 1 == shadow_count};
      queue_result(res);
    end
  endtask

  // scoreboard: compare each output transaction with the oldest expectation
  always @(posedge clk) begin
    particle_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction kind %0d", out_tuser);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.kind == KIND_FULL) full_seen++;
        if (out_tuser !== exp_r.kind) begin
          $error("result_kind expected %0d actual %0d", exp_r.kind, out_tuser);
          fail_count++;
        end
        if (out_tdata[5:0] !== exp_r.idx) begin
          $error("particle_index expected %0d actual %0d", exp_r.idx, out_tdata[5:0]);
          fail_count++;
        end
        if (out_tdata[37:6] !== exp_r.px) begin
          $error("position_x expected %h actual %h", exp_r.px, out_tdata[37:6]);
          fail_count++;
        end
        if (out_tdata[69:38] !== exp_r.py) begin
          $error("position_y expected %h actual %h", exp_r.py, out_tdata[69:38]);
          fail_count++;
        end
        if (out_tlast !== exp_r.last) begin
          $error("last expected %0d actual %0d", exp_r.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // send one transaction on the input stream; entered just after a rising edge
  task automatic send_item(logic cmd, logic [31:0] sx, logic [31:0] sy,
                           logic [5:0] sr, logic [15:0] dt);
    @(negedge clk);
    while (($urandom % 100) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {2'b00, dt, sr, sy, sx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_motion(cmd, sx, sy, sr, dt);
    items_sent++;
  endtask

  task automatic add_particle(logic [31:0] sx, logic [31:0] sy, logic [5:0] sr);
    send_item(CMD_ADD, sx, sy, sr, 16'($urandom));
  endtask

  task automatic step_world(logic [15:0] dt);
    send_item(CMD_STEP, $urandom, $urandom, 6'($urandom), dt);
  endtask

  // wait until every expected result is back, then let the block settle
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // apb write: setup then access cycle
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx == REG_WIDTH) win_w = value[11:0];
    else if (idx == REG_HEIGHT) win_h = value[11:0];
    else if (idx == REG_GRAVITY) grav = value[15:0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_world(logic [31:0] w, logic [31:0] h, logic [31:0] g);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_GRAVITY, g);
  endtask

  // empty table, overlap, coincident pair, field extremes, radius zero
  task automatic test_directed();
    step_world(16'hFFFF);
    add_particle(32'h0064_0000, 32'h0064_0000, 6'd10);
    add_particle(32'h0064_0000, 32'h0064_0000, 6'd10);
    add_particle(32'h0069_0000, 32'h0064_0000, 6'd10);
    step_world(16'd1092);
    step_world(16'd0);
    add_particle(32'h7FFF_FFFF, 32'h8000_0000, 6'd63);
    add_particle(32'h8000_0000, 32'h7FFF_FFFF, 6'd0);
    step_world(16'hFFFF);
    drain_results();
    set_world(32'hFFFF_F001, 32'hFFFF_F001, 32'hFFFF_FFFF);
    step_world(16'hFFFF);
    step_world(16'h5555);
    drain_results();
    set_world(32'd4095, 32'd4095, 32'd0);
    step_world(16'hAAAA);
    drain_results();
    set_world(32'd1600, 32'd900, 32'd981);
    step_world(16'd1092);
  endtask

  // random adds and steps under one idling profile
  task automatic test_random_phase(int n, int idle_pct, int stall_pct);
    logic [31:0] sx, sy;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n; k++) begin
      if (shadow_count < SMALL_TABLE && ($urandom % 2)) begin
        if ($urandom % 5 != 0) begin
          sx = 32'($urandom % ((win_w << 16) + 1));
          sy = 32'($urandom % ((win_h << 16) + 1));
        end else begin
          sx = $urandom;
          sy = $urandom;
        end
        add_particle(sx, sy, 6'($urandom_range(0, 63)));
      end else begin
        step_world(($urandom % 4 != 0) ? 16'($urandom_range(0, 4096)) : 16'($urandom));
      end
    end
    drain_results();
  endtask

  // sender holds off until every result is in, then carries on
  task automatic test_pause_drain();
    step_world(16'd2000);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    step_world(16'd500);
    drain_results();
  endtask

  // fill the table to the top, then overflow it
  task automatic test_full_table();
    send_idle_pct = 0;
    recv_stall_pct = 24;
    while (shadow_count < TABLE_SIZE)
      add_particle($urandom % (32'd1600 << 16), $urandom % (32'd900 << 16),
                   6'($urandom_range(1, 4)));
    add_particle($urandom, $urandom, 6'($urandom));
    add_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
    step_world(16'd1092);
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain_results();
    test_random_phase(18, 0, 0);
    set_world(32'd4095, 32'd4095, 32'd0);
    test_random_phase(18, 88, 0);
    set_world(32'd200, 32'd150, 32'd65535);
    test_random_phase(18, 0, 88);
    set_world(32'd1600, 32'd900, 32'd981);
    test_random_phase(18, 24, 24);
    test_pause_drain();
    test_full_table();
    repeat (200) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    $display("covered %0d input transactions, %0d results (%0d table-full), four idling profiles",
             items_sent, results_seen, full_seen);
    if (fail_count == 0) begin
      $display("PASS verlet_particle_step");
    end else begin
      $display("FAIL verlet_particle_step");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/vps_pkg.sv
rtl/core/vps_ctrl.sv
rtl/core/vps_dpath.sv
rtl/core/verlet_particle_step.sv
tb/tb_top.sv
